@@ sv/sdi12_command_framer_defines.svh @@
// Assertion macros for the SDI-12 command framer.
`ifndef SDI12_COMMAND_FRAMER_DEFINES_SVH
`define SDI12_COMMAND_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define SDI12CF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SDI12CF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SDI12CF_ASSERT(name, prop, msg)
`define SDI12CF_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

@@ sv/sdi12cf_pkg.sv @@
// Shared types, character codes and helpers for the SDI-12 command framer.
`default_nettype none

package sdi12cf_pkg;

   localparam int MaxFrameLen = 16;
   localparam int LenWidth    = 5;
   localparam int IdleWidth   = 10;
   localparam int StreamWidth = 16;
   localparam int LockWidth   = 10;
   localparam int AddrWidth   = 7;
   localparam int CountWidth  = 4;
   localparam int CsrWidth    = 16;
   localparam int CsrIdxWidth = 3;

   localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MaxFrameLen);

   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // req_tuser codes
   localparam logic TypeByte = 1'b0;
   localparam logic TypeTick = 1'b1;

   localparam logic [7:0] CharSpace  = 8'd32;
   localparam logic [7:0] CharTilde  = 8'd126;
   localparam logic [7:0] CharBang   = 8'h21;
   localparam logic [7:0] CharQuery  = 8'h3F;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperM = 8'h4D;
   localparam logic [7:0] CharUpperD = 8'h44;
   localparam logic [7:0] CharUpperR = 8'h52;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharOne    = 8'h31;
   localparam logic [7:0] CharTwo    = 8'h32;
   localparam logic [7:0] CharThree  = 8'h33;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;

   localparam logic [CountWidth-1:0] MaxDigit = CountWidth'(9);

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_ADDRESS   = 3'd0,
      CSR_VALUE_COUNT     = 3'd1,
      CSR_FRAME_TIMEOUT   = 3'd2,
      CSR_STREAM_INTERVAL = 3'd3,
      CSR_LOCKOUT         = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_THP   = 2'd1,
      KIND_LIGHT = 2'd2,
      KIND_ALL   = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      JOB_ECHO    = 2'd0,   // chr CR LF
      JOB_MEASURE = 2'd1,   // chr 0 0 3 digit CR LF
      JOB_REQUEST = 2'd2    // one data request word
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      out_kind_type            req_kind;
      logic [AddrWidth-1:0]    chr;
      logic [CountWidth-1:0]   digit;
   } job_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

`default_nettype wire

@@ sv/sdi12cf_front.sv @@
// Front end: framing, timers, config registers and command decode into reply jobs.
`default_nettype none

module sdi12cf_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic                               req_tuser,   // [0] 0 byte, 1 tick
   input  wire logic [7:0]                         req_tdata,   // [7:0] rx_byte
   input  wire logic                               csr_we,
   input  wire logic [sdi12cf_pkg::CsrIdxWidth-1:0] csr_addr,
   input  wire logic [sdi12cf_pkg::CsrWidth-1:0]   csr_wdata,
   output logic                                    job_valid,
   output sdi12cf_pkg::job_type                    job,
   input  wire logic                               job_ready
);
   import sdi12cf_pkg::*;

   logic [CountWidth-1:0]  value_count_ff;
   logic [IdleWidth-1:0]   timeout_ff;
   logic [StreamWidth-1:0] interval_ff;
   logic [LockWidth-1:0]   lockout_cfg_ff;

   logic                   receiving_ff, receiving_in;
   logic [LenWidth-1:0]    len_ff, len_in;
   logic [AddrWidth-1:0]   head_ff [3];
   logic [AddrWidth-1:0]   head_in [3];
   logic [AddrWidth-1:0]   addr_ff, addr_in;
   logic [IdleWidth-1:0]   idle_ff, idle_in;
   logic                   streaming_ff, streaming_in;
   logic [StreamWidth-1:0] scount_ff, scount_in;
   logic [LockWidth-1:0]   lock_ff, lock_in;

   logic                   accept;
   logic                   printable;
   logic                   valid_ch;
   logic [7:0]             h0, h1, h2, addr8;
   logic [IdleWidth-1:0]   idle_tick;
   logic [StreamWidth-1:0] scount_tick;
   logic [LockWidth-1:0]   lock_tick;
   logic [CountWidth-1:0]  digit;

   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;
   assign printable  = (req_tdata >= CharSpace) && (req_tdata <= CharTilde);
   assign valid_ch   = is_alnum(req_tdata) || (req_tdata == CharQuery);
   assign h0         = {1'b0, head_ff[0]};
   assign h1         = {1'b0, head_ff[1]};
   assign h2         = {1'b0, head_ff[2]};
   assign addr8      = {1'b0, addr_ff};
   assign digit      = (value_count_ff > MaxDigit) ? MaxDigit : value_count_ff;

   assign idle_tick   = (receiving_ff && idle_ff != '1) ? idle_ff + 1'b1 : idle_ff;
   assign scount_tick = (streaming_ff && scount_ff != '1) ? scount_ff + 1'b1 : scount_ff;
   assign lock_tick   = (lock_ff != '0) ? lock_ff - 1'b1 : lock_ff;

   always_comb begin
      receiving_in = receiving_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      addr_in      = addr_ff;
      idle_in      = idle_ff;
      streaming_in = streaming_ff;
      scount_in    = scount_ff;
      lock_in      = lock_ff;
      job_valid    = 1'b0;
      job.kind     = JOB_ECHO;
      job.req_kind = KIND_REPLY;
      job.chr      = addr_ff;
      job.digit    = digit;

      if (accept && req_tuser == TypeByte) begin
         if (lock_ff == '0 && printable) begin
            if (!receiving_ff) begin
               if (valid_ch) begin
                  head_in[0]   = req_tdata[AddrWidth-1:0];
                  len_in       = LenWidth'(1);
                  idle_in      = '0;
                  receiving_in = 1'b1;
               end
            end else if (req_tdata == CharBang) begin
               // any closed frame stops streaming, unless it is a new R0 request
               streaming_in = 1'b0;
               receiving_in = 1'b0;
               len_in       = '0;
               if (len_ff == LenWidth'(1) && h0 == CharQuery) begin
                  job_valid = 1'b1;
               end else if (len_ff >= LenWidth'(2) && h0 == addr8) begin
                  if (len_ff == LenWidth'(3) && h1 == CharUpperA) begin
                     if (is_alnum(h2)) begin
                        addr_in   = head_ff[2];
                        job.chr   = head_ff[2];
                        job_valid = 1'b1;
                     end
                  end else if (len_ff == LenWidth'(2) && h1 == CharUpperM) begin
                     job.kind  = JOB_MEASURE;
                     job_valid = 1'b1;
                  end else if (len_ff == LenWidth'(3) && h1 == CharUpperD && h2 == CharOne) begin
                     job.kind     = JOB_REQUEST;
                     job.req_kind = KIND_THP;
                     job_valid    = 1'b1;
                  end else if (len_ff == LenWidth'(3) && h1 == CharUpperD && h2 == CharTwo) begin
                     job.kind     = JOB_REQUEST;
                     job.req_kind = KIND_LIGHT;
                     job_valid    = 1'b1;
                  end else if (len_ff == LenWidth'(3) && h1 == CharUpperR && h2 == CharZero) begin
                     job.kind     = JOB_REQUEST;
                     job.req_kind = KIND_ALL;
                     streaming_in = 1'b1;
                     scount_in    = '0;
                     job_valid    = 1'b1;
                  end
               end
               if (job_valid) begin
                  lock_in = lockout_cfg_ff;
               end
            end else if (!valid_ch || len_ff >= MaxLen) begin
               receiving_in = 1'b0;
               len_in       = '0;
            end else begin
               if (len_ff < LenWidth'(3)) begin
                  head_in[len_ff[1:0]] = req_tdata[AddrWidth-1:0];
               end
               len_in  = len_ff + 1'b1;
               idle_in = '0;
            end
         end
      end else if (accept) begin
         idle_in   = idle_tick;
         scount_in = scount_tick;
         lock_in   = lock_tick;
         if (lock_tick == '0) begin
            if (receiving_ff && idle_tick > timeout_ff) begin
               receiving_in = 1'b0;
               len_in       = '0;
            end
            if (streaming_ff && scount_tick >= interval_ff) begin
               job.kind     = JOB_REQUEST;
               job.req_kind = KIND_ALL;
               job_valid    = 1'b1;
               scount_in    = '0;
               lock_in      = lockout_cfg_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= CountWidth'(4);
         timeout_ff     <= IdleWidth'(120);
         interval_ff    <= StreamWidth'(1000);
         lockout_cfg_ff <= LockWidth'(50);
         addr_ff        <= AddrWidth'(48);
         receiving_ff   <= 1'b0;
         len_ff         <= '0;
         idle_ff        <= '0;
         streaming_ff   <= 1'b0;
         scount_ff      <= '0;
         lock_ff        <= '0;
      end else begin
         receiving_ff <= receiving_in;
         len_ff       <= len_in;
         idle_ff      <= idle_in;
         streaming_ff <= streaming_in;
         scount_ff    <= scount_in;
         lock_ff      <= lock_in;
         if (csr_we && csr_addr == CSR_START_ADDRESS) begin
            addr_ff <= csr_wdata[AddrWidth-1:0];
         end else begin
            addr_ff <= addr_in;
         end
         if (csr_we && csr_addr == CSR_VALUE_COUNT) begin
            value_count_ff <= csr_wdata[CountWidth-1:0];
         end
         if (csr_we && csr_addr == CSR_FRAME_TIMEOUT) begin
            timeout_ff <= csr_wdata[IdleWidth-1:0];
         end
         if (csr_we && csr_addr == CSR_STREAM_INTERVAL) begin
            interval_ff <= csr_wdata[StreamWidth-1:0];
         end
         if (csr_we && csr_addr == CSR_LOCKOUT) begin
            lockout_cfg_ff <= csr_wdata[LockWidth-1:0];
         end
      end
   end

   // head characters are payload: only read at positions written in this frame
   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

endmodule

`default_nettype wire

@@ sv/sdi12cf_queue.sv @@
// Small job queue between the framer front end and the reply sequencer.
`default_nettype none

module sdi12cf_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire sdi12cf_pkg::job_type push_job,
   output logic                      push_ready,
   output logic                      pop_valid,
   output sdi12cf_pkg::job_type      pop_job,
   input  wire logic                 pop
);
   import sdi12cf_pkg::*;

   job_type                    entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]   count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = (count_ff != QueueCntWidth'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ sv/sdi12cf_back.sv @@
// Back end: expands one reply job into result words through an output register.
`default_nettype none

module sdi12cf_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  wire sdi12cf_pkg::job_type job,
   output logic                      job_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [1:0]                rsp_tuser,   // [1:0] out_kind
   output logic [7:0]                rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tlast
);
   import sdi12cf_pkg::*;

   logic         rsp_valid_ff;
   out_kind_type rsp_kind_ff;
   logic [7:0]   rsp_data_ff;
   logic         rsp_last_ff;
   logic [2:0]   idx_ff, idx_in;

   out_kind_type word_kind;
   logic [7:0]   word_data;
   logic         word_last;
   logic         load;
   logic [7:0]   chr8;

   assign chr8 = {1'b0, job.chr};
   assign load = job_valid && (!rsp_valid_ff || rsp_tready);
   assign job_pop = load && word_last;

   always_comb begin
      word_kind = KIND_REPLY;
      word_data = chr8;
      word_last = 1'b0;
      unique case (job.kind)
         JOB_ECHO: begin
            unique case (idx_ff)
               3'd0:    word_data = chr8;
               3'd1:    word_data = CharCr;
               default: begin
                  word_data = CharLf;
                  word_last = 1'b1;
               end
            endcase
         end
         JOB_MEASURE: begin
            unique case (idx_ff)
               3'd0:    word_data = chr8;
               3'd1:    word_data = CharZero;
               3'd2:    word_data = CharZero;
               3'd3:    word_data = CharThree;
               3'd4:    word_data = CharZero + {4'b0, job.digit};
               3'd5:    word_data = CharCr;
               default: begin
                  word_data = CharLf;
                  word_last = 1'b1;
               end
            endcase
         end
         JOB_REQUEST: begin
            word_kind = job.req_kind;
            word_last = 1'b1;
         end
         default: word_last = 1'b1;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = word_last ? 3'd0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff <= word_kind;
         rsp_data_ff <= word_data;
         rsp_last_ff <= word_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/sdi12_command_framer.sv @@
// SDI-12 command framer top level: front end, job queue and reply sequencer.
// Every input word (received byte or 1 ms tick) is accepted whenever the
// four-entry job queue has room, so bytes and ticks may come back to back. A word that
// completes a command pushes one reply job; the back end turns a job into result words
// at one word per cycle when the consumer is ready: 3 words for address replies, 7 for
// the measure reply, 1 for a data request. Sustained rate is therefore set by the
// back-end word sequencer whenever commands produce replies.
// Configuration writes take effect on the next cycle; registers have no read-back.
`default_nettype none

`include "sdi12_command_framer_defines.svh"

module sdi12_command_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,    // [0] req_type
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,    // [1:0] out_kind
   output logic [7:0]       rsp_tdata,    // [7:0] out_byte
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);
   import sdi12cf_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    push_ready;
   logic    pop_valid;
   job_type pop_job;
   logic    pop;

   sdi12cf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .job_valid  (push_valid),
      .job        (push_job),
      .job_ready  (push_ready)
   );

   sdi12cf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   sdi12cf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // data requests are single-word replies
   `SDI12CF_ASSERT(a_request_is_last, rsp_tvalid && (rsp_tuser != KIND_REPLY) |-> rsp_tlast, "data request word without tlast")
   // text replies always end in LF
   `SDI12CF_ASSERT(a_reply_ends_lf, rsp_tvalid && rsp_tlast && (rsp_tuser == KIND_REPLY) |-> (rsp_tdata == CharLf), "reply does not end in LF")
   // output register is empty right after reset
   `SDI12CF_ASSERT_ALWAYS(a_reset_clears_out, reset |=> !rsp_tvalid, "result word valid after reset")

endmodule

`default_nettype wire
